// ===== src/pst_pkg.sv =====
package pst_pkg;

    // Field widths of the position and time inputs.
    localparam int POS_W  = 32;
    localparam int TIME_W = 48;

    // Result field widths.
    localparam int SPD_W  = 32;
    localparam int DIST_W = 48;

    // Magnitude of a coordinate difference, and the root of the sum of two squares.
    localparam int DIFF_W = POS_W + 1;
    localparam int ROOT_W = DIFF_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Scaling by 1000 ms per second adds ten bits.
    localparam int MS_W   = 10;
    localparam int PROD_W = ROOT_W + MS_W;
    localparam int DVD_W  = (PROD_W > SPD_W) ? PROD_W : SPD_W + 1;
    localparam int HI_W   = DVD_W - SPD_W;

    // Step counter covers the longest iterative phase.
    localparam int CNT_W  = $clog2(ROOT_W);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic store;
        logic start;
        logic sq_step;
        logic root_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_prev;
    } t_dp_status;

endpackage

// ===== src/pst_ctrl.sv =====
module pst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    input  logic                i_out_stall,
    input  pst_pkg::t_dp_status i_status,
    output pst_pkg::t_ctl_cmd   o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQR   = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [pst_pkg::CNT_W-1:0] r_cnt;
    logic [pst_pkg::CNT_W-1:0] n_cnt;
    logic                      r_out_valid;
    logic                      n_out_valid;
    pst_pkg::t_ctl_cmd         cmd;

    // Sequence: accept, square, root, divider load, divide, hand off the result.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd) begin
                        cmd.clear = 1'b1;
                    end else if (!i_status.have_prev) begin
                        cmd.store = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = S_SQR;
                        n_cnt     = '0;
                    end
                end
            end
            S_SQR: begin
                cmd.sq_step = 1'b1;
                if (r_cnt == pst_pkg::CNT_W'(pst_pkg::DIFF_W - 1)) begin
                    n_state = S_ROOT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (r_cnt == pst_pkg::CNT_W'(pst_pkg::ROOT_W - 1)) begin
                    n_state = S_DLOAD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DLOAD: begin
                cmd.div_load = 1'b1;
                n_state      = S_DIV;
                n_cnt        = '0;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == pst_pkg::CNT_W'(pst_pkg::SPD_W - 1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register holds a beat until the far side takes it.
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/pst_datapath.sv =====
module pst_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pst_pkg::t_ctl_cmd             i_cmd,
    input  logic [pst_pkg::TIME_W-1:0]    i_sample_time,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_z,
    output pst_pkg::t_dp_status           o_status,
    output logic [pst_pkg::SPD_W-1:0]     o_planar_speed,
    output logic [pst_pkg::SPD_W-1:0]     o_lift_speed,
    output logic [pst_pkg::DIST_W-1:0]    o_distance_total,
    output logic                          o_time_error
);

    // Magnitude of the difference of two signed positions.
    function automatic logic [pst_pkg::DIFF_W-1:0] abs_diff(
        input logic [pst_pkg::POS_W-1:0] a,
        input logic [pst_pkg::POS_W-1:0] b
    );
        logic [pst_pkg::DIFF_W-1:0] d;
        d = {a[pst_pkg::POS_W-1], a} - {b[pst_pkg::POS_W-1], b};
        if (d[pst_pkg::DIFF_W-1]) begin
            d = -d;
        end
        return d;
    endfunction

    // x * 1000 as x * 1024 - x * 32 + x * 8.
    function automatic logic [pst_pkg::PROD_W-1:0] times_ms(
        input logic [pst_pkg::ROOT_W-1:0] x
    );
        logic [pst_pkg::PROD_W-1:0] w;
        w = pst_pkg::PROD_W'(x);
        return (w << pst_pkg::MS_W) - (w << 5) + (w << 3);
    endfunction

    // One restoring division step: returns the new remainder and quotient shift.
    function automatic logic [pst_pkg::TIME_W+pst_pkg::SPD_W-1:0] div_iter(
        input logic [pst_pkg::TIME_W-1:0] rem,
        input logic [pst_pkg::SPD_W-1:0]  q,
        input logic [pst_pkg::TIME_W-1:0] dt
    );
        logic [pst_pkg::TIME_W:0]   t;
        logic [pst_pkg::TIME_W:0]   diff;
        logic                       ge;
        logic [pst_pkg::TIME_W-1:0] rem_n;
        t    = {rem, q[pst_pkg::SPD_W-1]};
        diff = t - {1'b0, dt};
        ge   = (t >= {1'b0, dt});
        if (ge) begin
            rem_n = diff[pst_pkg::TIME_W-1:0];
        end else begin
            rem_n = t[pst_pkg::TIME_W-1:0];
        end
        return {rem_n, q[pst_pkg::SPD_W-2:0], ge};
    endfunction

    logic                         r_have_prev;
    logic [pst_pkg::TIME_W-1:0]   r_prev_time;
    logic [pst_pkg::POS_W-1:0]    r_prev_x;
    logic [pst_pkg::POS_W-1:0]    r_prev_y;
    logic [pst_pkg::POS_W-1:0]    r_prev_z;
    logic [pst_pkg::DIST_W-1:0]   r_dist;

    logic                         r_err;
    logic [pst_pkg::TIME_W-1:0]   r_dt;
    logic [pst_pkg::DIFF_W-1:0]   r_dz;

    logic [pst_pkg::RAD_W-1:0]    r_acc;
    logic [pst_pkg::RAD_W-1:0]    r_mx;
    logic [pst_pkg::RAD_W-1:0]    r_my;
    logic [pst_pkg::DIFF_W-1:0]   r_bx;
    logic [pst_pkg::DIFF_W-1:0]   r_by;

    logic [pst_pkg::REM_W-1:0]    r_rem;
    logic [pst_pkg::ROOT_W-1:0]   r_root;

    logic [pst_pkg::TIME_W-1:0]   r_prem;
    logic [pst_pkg::SPD_W-1:0]    r_pq;
    logic                         r_psat;
    logic [pst_pkg::TIME_W-1:0]   r_lrem;
    logic [pst_pkg::SPD_W-1:0]    r_lq;
    logic                         r_lsat;

    logic [pst_pkg::DIFF_W-1:0]   dx;
    logic [pst_pkg::DIFF_W-1:0]   dy;
    logic [pst_pkg::DIFF_W-1:0]   dz;
    logic [pst_pkg::RAD_W-1:0]    sq_add_x;
    logic [pst_pkg::RAD_W-1:0]    sq_add_y;
    logic [pst_pkg::REM_W-1:0]    rt_try;
    logic [pst_pkg::REM_W-1:0]    rt_trial;
    logic                         rt_ge;
    logic [pst_pkg::DVD_W-1:0]    p_dvd;
    logic [pst_pkg::DVD_W-1:0]    l_dvd;
    logic [pst_pkg::HI_W-1:0]     p_hi;
    logic [pst_pkg::HI_W-1:0]     l_hi;
    logic [pst_pkg::DIST_W:0]     dist_sum;
    logic [pst_pkg::TIME_W+pst_pkg::SPD_W-1:0] p_next;
    logic [pst_pkg::TIME_W+pst_pkg::SPD_W-1:0] l_next;

    // Differences against the stored sample.
    assign dx = abs_diff(i_pos_x, r_prev_x);
    assign dy = abs_diff(i_pos_y, r_prev_y);
    assign dz = abs_diff(i_pos_z, r_prev_z);

    // Shift-and-add squaring of both differences, one bit of each a cycle.
    assign sq_add_x = r_bx[0] ? r_mx : '0;
    assign sq_add_y = r_by[0] ? r_my : '0;

    // Digit-by-digit square root, two radicand bits a cycle.
    assign rt_try   = {r_rem[pst_pkg::ROOT_W-1:0], r_acc[pst_pkg::RAD_W-1 -: 2]};
    assign rt_trial = {r_root, 2'b01};
    assign rt_ge    = (rt_try >= rt_trial);

    // Dividends scaled to milliseconds; besides a time error, the high part alone decides saturation.
    assign p_dvd = pst_pkg::DVD_W'(times_ms(r_root));
    assign l_dvd = pst_pkg::DVD_W'(times_ms(pst_pkg::ROOT_W'(r_dz)));
    assign p_hi  = p_dvd[pst_pkg::DVD_W-1:pst_pkg::SPD_W];
    assign l_hi  = l_dvd[pst_pkg::DVD_W-1:pst_pkg::SPD_W];

    assign dist_sum = {1'b0, r_dist} + (pst_pkg::DIST_W+1)'(r_root);

    assign p_next = div_iter(r_prem, r_pq, r_dt);
    assign l_next = div_iter(r_lrem, r_lq, r_dt);

    // Tracking state: previous sample and the saturating distance total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_have_prev <= 1'b0;
            r_prev_time <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_dist      <= '0;
        end else begin
            if (i_cmd.store || i_cmd.start) begin
                r_have_prev <= 1'b1;
                r_prev_time <= i_sample_time;
                r_prev_x    <= i_pos_x;
                r_prev_y    <= i_pos_y;
                r_prev_z    <= i_pos_z;
            end
            if (i_cmd.div_load) begin
                r_dist <= dist_sum[pst_pkg::DIST_W] ? '1 : dist_sum[pst_pkg::DIST_W-1:0];
            end
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_err  <= (i_sample_time <= r_prev_time);
            r_dt   <= i_sample_time - r_prev_time;
            r_dz   <= dz;
            r_acc  <= '0;
            r_mx   <= pst_pkg::RAD_W'(dx);
            r_my   <= pst_pkg::RAD_W'(dy);
            r_bx   <= dx;
            r_by   <= dy;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sq_step) begin
            r_acc <= r_acc + sq_add_x + sq_add_y;
            r_mx  <= r_mx << 1;
            r_my  <= r_my << 1;
            r_bx  <= r_bx >> 1;
            r_by  <= r_by >> 1;
        end
        if (i_cmd.root_step) begin
            r_rem  <= rt_ge ? (rt_try - rt_trial) : rt_try;
            r_root <= {r_root[pst_pkg::ROOT_W-2:0], rt_ge};
            r_acc  <= r_acc << 2;
        end
        if (i_cmd.div_load) begin
            r_prem <= pst_pkg::TIME_W'(p_hi);
            r_pq   <= p_dvd[pst_pkg::SPD_W-1:0];
            r_psat <= r_err || (r_dt <= pst_pkg::TIME_W'(p_hi));
            r_lrem <= pst_pkg::TIME_W'(l_hi);
            r_lq   <= l_dvd[pst_pkg::SPD_W-1:0];
            r_lsat <= r_err || (r_dt <= pst_pkg::TIME_W'(l_hi));
        end
        if (i_cmd.div_step) begin
            r_prem <= p_next[pst_pkg::TIME_W+pst_pkg::SPD_W-1:pst_pkg::SPD_W];
            r_pq   <= p_next[pst_pkg::SPD_W-1:0];
            r_lrem <= l_next[pst_pkg::TIME_W+pst_pkg::SPD_W-1:pst_pkg::SPD_W];
            r_lq   <= l_next[pst_pkg::SPD_W-1:0];
        end
    end

    // Result register, loaded once the far side has room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_planar_speed   <= r_psat ? '1 : r_pq;
            o_lift_speed     <= r_lsat ? '1 : r_lq;
            o_distance_total <= r_dist;
            o_time_error     <= r_err;
        end
    end

    assign o_status.have_prev = r_have_prev;

endmodule

// ===== src/position_speed_tracker.sv =====
// Channel  | Direction | Handshake                  | Fields
// input    | in        | i_in_valid / o_in_stall    | i_cmd, i_sample_time, i_pos_x/y/z
// output   | out       | o_out_valid / i_out_stall  | o_planar_speed, o_lift_speed,
//          |           |                            | o_distance_total, o_time_error
//
// A disconnect beat or the first sample after a clear is handled in the idle state.
// Any later sample runs through accept, 33 squaring steps, 34 root steps,
// a divider load, 32 steps of the two parallel dividers and the result load.
// Reset is synchronous and active low; it clears the stored sample and the total.
// The result register holds a beat under stall while the next input is taken;
// a finished item waits in its last step only if a result is still held.
module position_speed_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [pst_pkg::TIME_W-1:0]       i_sample_time,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [pst_pkg::POS_W-1:0] i_pos_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [pst_pkg::SPD_W-1:0]        o_planar_speed,
    output logic [pst_pkg::SPD_W-1:0]        o_lift_speed,
    output logic [pst_pkg::DIST_W-1:0]       o_distance_total,
    output logic                             o_time_error
);

    pst_pkg::t_ctl_cmd   ctl_cmd;
    pst_pkg::t_dp_status dp_status;

    // Sequencer for the iterative phases.
    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_cmd),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (ctl_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Squaring, root and division datapath with the tracking state.
    pst_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (ctl_cmd),
        .i_sample_time    (i_sample_time),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .o_status         (dp_status),
        .o_planar_speed   (o_planar_speed),
        .o_lift_speed     (o_lift_speed),
        .o_distance_total (o_distance_total),
        .o_time_error     (o_time_error)
    );

    // No result beat is pending in the cycle after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid right after reset");

    // A timing error always comes with both speeds saturated.
    a_err_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_time_error) |-> (o_planar_speed == '1 && o_lift_speed == '1))
        else $error("time error without saturated speeds");

    // A new result never appears in the cycle after an input beat is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after an input beat");

endmodule
